// ===== rtl/postfix_expression_evaluator_macros.svh =====
// Assertion helpers for the checker of the postfix evaluator.
// Each expects clk and rst_n in scope.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// Same-cycle implication.
`define PFE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pfe_pkg.sv =====
`default_nettype none

package pfe_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int WORD_W          = 32;
    localparam int SYM_W           = 8;
    localparam int IMM_W           = SYM_W + 1;
    localparam int STATUS_W        = 2;

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_UNDER = 2'd1;
    localparam status_t ST_OVER  = 2'd2;
    localparam status_t ST_DIVZ  = 2'd3;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic signed [IMM_W-1:0] imm;
        logic                    last;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/pfe_ram.sv =====
`default_nettype none

module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pfe_div.sv =====
`default_nettype none

module pfe_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pfe_pkg::WORD_W-1:0]  dividend,
    input  wire logic [pfe_pkg::WORD_W-1:0]  divisor,
    output logic                             done,
    output logic      [pfe_pkg::WORD_W-1:0]  quotient
);

    import pfe_pkg::*;

    localparam int STEP_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg, quo_reg[WORD_W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
            dvs_next  = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
            neg_next  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W])
            begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (WORD_W'(0) - quo_reg) : quo_reg;

endmodule

`default_nettype wire

// ===== rtl/pfe_front.sv =====
`default_nettype none

module pfe_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [pfe_pkg::SYM_W-1:0]  s_tdata,  // symbol[7:0]
    input  wire logic                       s_tlast,
    output logic                            cmd_valid,
    output pfe_pkg::cmd_t                   cmd,
    input  wire logic                       cmd_ready
);

    import pfe_pkg::*;

    localparam int QD  = 2;
    localparam int QAW = $clog2(QD);

    cmd_t           q_reg [QD];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   fill_reg, fill_next;

    cmd_t           in_cmd;
    logic           push;
    logic           pop;

    always_comb
    begin
        case (s_tdata)
            CH_PLUS:  in_cmd.op = OP_ADD;
            CH_MINUS: in_cmd.op = OP_SUB;
            CH_STAR:  in_cmd.op = OP_MUL;
            CH_SLASH: in_cmd.op = OP_DIV;
            default:  in_cmd.op = OP_PUSH;
        endcase
        in_cmd.imm  = $signed({1'b0, s_tdata} - {1'b0, CH_ZERO});
        in_cmd.last = s_tlast;
    end

    assign s_tready  = (fill_reg != (QAW+1)'(QD));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QD - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QD - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + (QAW+1)'(1);
            2'b01:   fill_next = fill_reg - (QAW+1)'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pfe_exec.sv =====
`default_nettype none

module pfe_exec #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  wire pfe_pkg::cmd_t                 cmd,
    output logic                               cmd_ready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [pfe_pkg::WORD_W-1:0]    m_tdata,  // value[31:0]
    output logic      [pfe_pkg::STATUS_W-1:0]  m_tuser   // status[1:0]
);

    import pfe_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_POP_R = 10'b0000000010,
        S_POP_L = 10'b0000000100,
        S_GET_L = 10'b0000001000,
        S_EXEC  = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_PUSH  = 10'b0001000000,
        S_FPOP  = 10'b0010000000,
        S_FGET  = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    status_t           err_reg, err_next;
    op_t               op_reg, op_next;
    logic              last_reg, last_next;
    logic              pop_ok_reg, pop_ok_next;
    logic [WORD_W-1:0] rhs_reg, rhs_next;
    logic [WORD_W-1:0] lhs_reg, lhs_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    status_t           out_stat_reg, out_stat_next;

    logic [CW-1:0]     cnt_m1;
    logic              ram_we;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;
    logic              div_start;
    logic              div_done;
    logic [WORD_W-1:0] div_quo;

    function automatic status_t note_err(status_t cur, status_t code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    assign cnt_m1 = cnt_reg - CW'(1);

    pfe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (res_reg),
        .re    (ram_re),
        .raddr (cnt_m1[AW-1:0]),
        .rdata (ram_rdata)
    );

    pfe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lhs_reg),
        .divisor  (rhs_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        pop_ok_next    = pop_ok_reg;
        rhs_next       = rhs_reg;
        lhs_next       = lhs_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_stat_next  = out_stat_reg;
        cmd_ready      = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next    = cmd.op;
                    last_next  = cmd.last;
                    res_next   = {{(WORD_W-IMM_W){cmd.imm[IMM_W-1]}}, cmd.imm};
                    state_next = (cmd.op == OP_PUSH) ? S_PUSH : S_POP_R;
                end
            end
            S_POP_R, S_POP_L, S_FPOP:
            begin
                if (state_reg == S_POP_L)
                begin
                    rhs_next = pop_ok_reg ? ram_rdata : '0;
                end
                if (cnt_reg != '0)
                begin
                    ram_re      = 1'b1;
                    cnt_next    = cnt_m1;
                    pop_ok_next = 1'b1;
                end
                else
                begin
                    pop_ok_next = 1'b0;
                    err_next    = note_err(err_reg, ST_UNDER);
                end
                case (state_reg)
                    S_POP_R: state_next = S_POP_L;
                    S_POP_L: state_next = S_GET_L;
                    default: state_next = S_FGET;
                endcase
            end
            S_GET_L:
            begin
                lhs_next   = pop_ok_reg ? ram_rdata : '0;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_PUSH;
                case (op_reg)
                    OP_ADD: res_next = lhs_reg + rhs_reg;
                    OP_SUB: res_next = lhs_reg - rhs_reg;
                    OP_MUL: res_next = lhs_reg * rhs_reg;
                    OP_DIV:
                    begin
                        if (rhs_reg == '0)
                        begin
                            err_next = note_err(err_reg, ST_DIVZ);
                            res_next = '0;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default: res_next = res_reg;
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quo;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (cnt_reg >= CW'(STACK_DEPTH))
                begin
                    err_next = note_err(err_reg, ST_OVER);
                end
                else
                begin
                    ram_we   = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                state_next = last_reg ? S_FPOP : S_IDLE;
            end
            S_FGET:
            begin
                res_next   = pop_ok_reg ? ram_rdata : '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    out_stat_next  = err_reg;
                    cnt_next       = '0;
                    err_next       = ST_OK;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        last_reg     <= last_next;
        pop_ok_reg   <= pop_ok_next;
        rhs_reg      <= rhs_next;
        lhs_reg      <= lhs_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        out_stat_reg <= out_stat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_stat_reg;

endmodule

`default_nettype wire

// ===== rtl/postfix_expression_evaluator.sv =====
// Evaluates a postfix expression streamed one character per item, with tlast on
// the final character, and returns one result per expression: the 32-bit value
// left on top and a status (ok, underflow, overflow, divide by zero; the first
// error wins). A two-item input queue decouples the input from the executing
// sequencer, and an output register lets the next expression start while a
// result waits. Per item the sequencer steps through idle and push for a digit,
// and through idle, two pops, fetch of the left operand, execute and push for
// + - and *; / adds a wait on a one-bit-per-cycle restoring divider (32 steps)
// unless the divisor is zero. The item with tlast adds a final pop and the
// hand-off, which stalls while a previous result still waits. Each pop has its
// own state because the value stack's memory has a registered read. The stack
// holds STACK_DEPTH values; it needs no clearing after reset.
`default_nettype none

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pfe_pkg::SYM_W-1:0]     s_tdata,  // symbol[7:0]
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [pfe_pkg::WORD_W-1:0]    m_tdata,  // value[31:0]
    output logic      [pfe_pkg::STATUS_W-1:0]  m_tuser   // status[1:0]
);

    import pfe_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    pfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    pfe_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/pfe_checker.sv =====
`default_nettype none

`include "postfix_expression_evaluator_macros.svh"

module pfe_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          s_tlast,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [pfe_pkg::WORD_W-1:0]    m_tdata,
    input wire logic [pfe_pkg::STATUS_W-1:0]  m_tuser
);

    import pfe_pkg::*;

    logic [3:0] pending_reg, pending_next;
    logic       in_last;
    logic       out_take;

    assign in_last  = s_tvalid && s_tready && s_tlast;
    assign out_take = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg + {3'b000, in_last} - {3'b000, out_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `PFE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `PFE_ASSERT_IMPL(a_no_extra_result, pending_reg == 4'd0, !m_tvalid, "result without a finished expression")
    `PFE_ASSERT_NEXT(a_no_early_result, in_last && pending_reg == 4'd0, !m_tvalid, "result appeared too soon after last item")

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (.*);

`default_nettype wire
